/* sv/lca_ests_pkg.sv */
package lca_ests_pkg;

    localparam int NODE_W  = 10;
    localparam int DEPTH_W = 10;
    localparam int ENTRY_W = DEPTH_W + NODE_W;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [NODE_W-1:0]  tour_node;
        logic [DEPTH_W-1:0] tour_depth;
        logic               tour_last;
        logic [NODE_W-1:0]  node_a;
        logic [NODE_W-1:0]  node_b;
    } lca_ests_req_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              error;
    } lca_ests_rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clr_step;
        logic load_do;
        logic bld_init;
        logic bld_rd;
        logic bld_wr;
        logic q_pos;
        logic q_ent;
        logic q_calc;
        logic q_tab;
        logic q_out;
    } lca_ests_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_done;
        logic tour_last;
        logic bld_done;
    } lca_ests_sts_t;

endpackage

/* sv/lca_ests_ctrl.sv */
module lca_ests_ctrl
    import lca_ests_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          req_cmd,
    input  lca_ests_sts_t sts,
    output lca_ests_cmd_t cmd,
    output logic          busy
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOAD,
        S_BINIT,
        S_BCHK,
        S_BRD,
        S_BWR,
        S_QPOS,
        S_QENT,
        S_QCALC,
        S_QTAB,
        S_QOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   busy_next;
    logic   accept;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (req_cmd == CMD_QUERY) ? S_QPOS : S_LOAD;
                end
            end
            S_LOAD:  state_next = sts.tour_last ? S_BINIT : S_IDLE;
            S_BINIT: state_next = S_BCHK;
            S_BCHK:  state_next = sts.bld_done ? S_IDLE : S_BRD;
            S_BRD:   state_next = S_BWR;
            S_BWR:   state_next = S_BCHK;
            S_QPOS:  state_next = S_QENT;
            S_QENT:  state_next = S_QCALC;
            S_QCALC: state_next = S_QTAB;
            S_QTAB:  state_next = S_QOUT;
            S_QOUT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            busy_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= busy_next;
        end
    end

    always_comb
    begin
        cmd          = '0;
        cmd.capture  = (state_reg == S_IDLE) && accept;
        cmd.clr_step = (state_reg == S_CLEAR);
        cmd.load_do  = (state_reg == S_LOAD);
        cmd.bld_init = (state_reg == S_BINIT);
        cmd.bld_rd   = (state_reg == S_BRD);
        cmd.bld_wr   = (state_reg == S_BWR);
        cmd.q_pos    = (state_reg == S_QPOS);
        cmd.q_ent    = (state_reg == S_QENT);
        cmd.q_calc   = (state_reg == S_QCALC);
        cmd.q_tab    = (state_reg == S_QTAB);
        cmd.q_out    = (state_reg == S_QOUT);
    end

endmodule

/* sv/lca_ests_dp.sv */
module lca_ests_dp
    import lca_ests_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int TOUR_CAPACITY = 2048,
    parameter int LEVELS        = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  lca_ests_req_t req,
    input  lca_ests_cmd_t cmd,
    output lca_ests_sts_t sts,
    output logic          done,
    output lca_ests_rsp_t rsp
);

    localparam int NODE_AW = $clog2(MAX_NODES);
    localparam int POS_W   = $clog2(TOUR_CAPACITY);
    localparam int LEN_W   = $clog2(TOUR_CAPACITY + 1);
    localparam int LV_W    = $clog2(LEVELS);
    localparam int SPAN_W  = ((LEN_W > LEVELS) ? LEN_W : LEVELS) + 1;

    // The later entry wins when depths tie.
    function automatic logic [ENTRY_W-1:0] pick_min(input logic [ENTRY_W-1:0] early,
                                                    input logic [ENTRY_W-1:0] late);
        return (late[ENTRY_W-1:NODE_W] <= early[ENTRY_W-1:NODE_W]) ? late : early;
    endfunction

    function automatic logic [LV_W-1:0] window_level(input logic [LEN_W-1:0] w);
        int p;
        p = 0;
        for (int k = 0; k < LEN_W; k++)
        begin
            if (w[k])
            begin
                p = k;
            end
        end
        if (p > LEVELS - 1)
        begin
            p = LEVELS - 1;
        end
        return LV_W'(p);
    endfunction

    logic [ENTRY_W-1:0] tab_mem [LEVELS][TOUR_CAPACITY];
    logic [POS_W-1:0]   lp_mem  [MAX_NODES];

    lca_ests_req_t      req_reg;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic               built_reg;
    logic               built_next;
    logic [NODE_AW-1:0] clr_cnt_reg;

    logic [LV_W-1:0]    lvl_reg;
    logic [POS_W-1:0]   idx_reg;
    logic               bld_done_reg;

    logic [ENTRY_W-1:0] rd_a_q;
    logic [ENTRY_W-1:0] rd_b_q;
    logic [POS_W-1:0]   la_q;
    logic [POS_W-1:0]   lb_q;

    logic               err_reg;
    logic               la_ok_reg;
    logic               lb_ok_reg;
    logic [POS_W-1:0]   l_reg;
    logic [POS_W-1:0]   r_reg;
    logic [LV_W-1:0]    p_reg;
    logic               done_reg;
    lca_ests_rsp_t      rsp_reg;

    logic [31:0]        a_wide;
    logic [31:0]        b_wide;
    logic [31:0]        n_wide;
    logic               a_ok;
    logic               b_ok;
    logic               n_ok;

    logic               new_tour;
    logic [LEN_W-1:0]   eff_len;
    logic               tour_full;

    logic [SPAN_W-1:0]  span;
    logic [SPAN_W-1:0]  half;
    logic [SPAN_W-1:0]  len_s;
    logic [LEN_W-1:0]   width;
    logic [ENTRY_W-1:0] best;

    logic [LV_W-1:0]    rd_a_lvl;
    logic [POS_W-1:0]   rd_a_pos;
    logic [LV_W-1:0]    rd_b_lvl;
    logic [POS_W-1:0]   rd_b_pos;
    logic               wr_en;
    logic [LV_W-1:0]    wr_lvl;
    logic [POS_W-1:0]   wr_pos;
    logic [ENTRY_W-1:0] wr_data;

    logic               lp_wr_en;
    logic [NODE_AW-1:0] lp_wr_addr;
    logic [POS_W-1:0]   lp_wr_data;

    assign a_wide = 32'(req_reg.node_a);
    assign b_wide = 32'(req_reg.node_b);
    assign n_wide = 32'(req_reg.tour_node);
    assign a_ok   = a_wide < 32'(MAX_NODES);
    assign b_ok   = b_wide < 32'(MAX_NODES);
    assign n_ok   = n_wide < 32'(MAX_NODES);

    // A load after a finished build starts a new tour from position zero.
    assign new_tour  = built_reg;
    assign eff_len   = new_tour ? '0 : len_reg;
    assign tour_full = (eff_len >= LEN_W'(TOUR_CAPACITY));

    assign span  = SPAN_W'(1) << lvl_reg;
    assign half  = span >> 1;
    assign len_s = SPAN_W'(len_reg);
    assign width = LEN_W'(r_reg) - LEN_W'(l_reg) + LEN_W'(1);
    assign best  = pick_min(rd_a_q, rd_b_q);

    always_comb
    begin
        rd_a_lvl = lvl_reg - LV_W'(1);
        rd_a_pos = idx_reg;
        rd_b_lvl = lvl_reg - LV_W'(1);
        rd_b_pos = POS_W'(SPAN_W'(idx_reg) + half);
        if (cmd.q_ent)
        begin
            rd_a_lvl = '0;
            rd_a_pos = la_q;
            rd_b_lvl = '0;
            rd_b_pos = lb_q;
        end
        else if (cmd.q_tab)
        begin
            rd_a_lvl = p_reg;
            rd_a_pos = l_reg;
            rd_b_lvl = p_reg;
            rd_b_pos = POS_W'(SPAN_W'(r_reg) + SPAN_W'(1) - (SPAN_W'(1) << p_reg));
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_lvl  = lvl_reg;
        wr_pos  = idx_reg;
        wr_data = pick_min(rd_a_q, rd_b_q);
        if (cmd.load_do)
        begin
            wr_en   = !tour_full;
            wr_lvl  = '0;
            wr_pos  = POS_W'(eff_len);
            wr_data = {req_reg.tour_depth, req_reg.tour_node};
        end
        else if (cmd.bld_wr)
        begin
            wr_en = 1'b1;
        end
    end

    always_comb
    begin
        lp_wr_en   = 1'b0;
        lp_wr_addr = n_wide[NODE_AW-1:0];
        lp_wr_data = POS_W'(eff_len);
        if (cmd.clr_step)
        begin
            lp_wr_en   = 1'b1;
            lp_wr_addr = clr_cnt_reg;
            lp_wr_data = '0;
        end
        else if (cmd.load_do)
        begin
            lp_wr_en = n_ok && !tour_full;
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        ovf_next   = ovf_reg;
        built_next = built_reg;
        if (cmd.load_do)
        begin
            len_next   = tour_full ? eff_len : eff_len + LEN_W'(1);
            ovf_next   = tour_full || (ovf_reg && !new_tour);
            built_next = req_reg.tour_last || (built_reg && !new_tour);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tab_mem[wr_lvl][wr_pos] <= wr_data;
        end
        rd_a_q <= tab_mem[rd_a_lvl][rd_a_pos];
        rd_b_q <= tab_mem[rd_b_lvl][rd_b_pos];
    end

    always_ff @(posedge clk)
    begin
        if (lp_wr_en)
        begin
            lp_mem[lp_wr_addr] <= lp_wr_data;
        end
        la_q <= lp_mem[a_wide[NODE_AW-1:0]];
        lb_q <= lp_mem[b_wide[NODE_AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg      <= '0;
            ovf_reg      <= 1'b0;
            built_reg    <= 1'b0;
            clr_cnt_reg  <= '0;
            lvl_reg      <= LV_W'(1);
            idx_reg      <= '0;
            bld_done_reg <= 1'b1;
            done_reg     <= 1'b0;
        end
        else
        begin
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
            built_reg <= built_next;
            done_reg  <= cmd.q_out;
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + NODE_AW'(1);
            end
            if (cmd.bld_init)
            begin
                lvl_reg      <= LV_W'(1);
                idx_reg      <= '0;
                bld_done_reg <= (len_reg < LEN_W'(2));
            end
            else if (cmd.bld_wr)
            begin
                if (SPAN_W'(idx_reg) + span + SPAN_W'(1) <= len_s)
                begin
                    idx_reg <= idx_reg + POS_W'(1);
                end
                else if ((lvl_reg == LV_W'(LEVELS - 1)) || ((span << 1) > len_s))
                begin
                    bld_done_reg <= 1'b1;
                end
                else
                begin
                    lvl_reg <= lvl_reg + LV_W'(1);
                    idx_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.q_pos)
        begin
            err_reg <= !built_reg || ovf_reg || !a_ok || !b_ok;
        end
        if (cmd.q_ent)
        begin
            l_reg     <= (la_q <= lb_q) ? la_q : lb_q;
            r_reg     <= (la_q <= lb_q) ? lb_q : la_q;
            la_ok_reg <= LEN_W'(la_q) < len_reg;
            lb_ok_reg <= LEN_W'(lb_q) < len_reg;
        end
        if (cmd.q_calc)
        begin
            // A node belongs to this tour only if its recorded position holds it.
            err_reg <= err_reg
                       || !(la_ok_reg && (rd_a_q[NODE_W-1:0] == req_reg.node_a))
                       || !(lb_ok_reg && (rd_b_q[NODE_W-1:0] == req_reg.node_b));
            p_reg   <= window_level(width);
        end
        if (cmd.q_out)
        begin
            rsp_reg.ancestor <= err_reg ? '0 : best[NODE_W-1:0];
            rsp_reg.error    <= err_reg;
        end
    end

    assign sts.clr_done  = (clr_cnt_reg == NODE_AW'(MAX_NODES - 1));
    assign sts.tour_last = req_reg.tour_last;
    assign sts.bld_done  = bld_done_reg;
    assign done          = done_reg;
    assign rsp           = rsp_reg;

endmodule

/* sv/lca_euler_tour_sparse_table_core.sv */
// Lowest-common-ancestor engine over an Euler tour with a sparse table of range minima.
// Requests enter on req when start is high and busy is low. A request with cmd = load
// carries one tour entry (node, depth); entries arrive in tour order and the one with
// tour_last set starts the table build. A request with cmd = query names two nodes.
// After the last entry the build walks the table one slot at a time through the
// separate bounds-check, read and write states of the controller; busy stays high.
// A query passes through a position lookup, a tour entry check, window selection,
// two table reads and a compare before the next request can be accepted.
// Then done is high for exactly one cycle with its result on rsp, registered from
// the compare state; a load produces no result. The receiver cannot stall the result.
// rsp.error is set for a query before a build, for an unknown node, or after tour
// overflow; ancestor then reads zero.
// After reset the block sweeps all MAX_NODES entries of the position memory, one
// entry per cycle, with busy high, before it takes its first request.
module lca_euler_tour_sparse_table_core
    import lca_ests_pkg::*;
#(
    parameter int MAX_NODES     = 1024,
    parameter int TOUR_CAPACITY = 2048,
    parameter int LEVELS        = 12
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  lca_ests_req_t req,
    output logic          done,
    output lca_ests_rsp_t rsp
);

    lca_ests_cmd_t cmd;
    lca_ests_sts_t sts;

    lca_ests_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .req_cmd (req.cmd),
        .sts     (sts),
        .cmd     (cmd),
        .busy    (busy)
    );

    lca_ests_dp #(
        .MAX_NODES     (MAX_NODES),
        .TOUR_CAPACITY (TOUR_CAPACITY),
        .LEVELS        (LEVELS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .sts   (sts),
        .done  (done),
        .rsp   (rsp)
    );

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted request");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bld_wr |-> $past(cmd.bld_rd))
        else $error("build write without its table read");

endmodule
